// ===== design/rci_pkg.sv =====
// Shared types and constants of the ray against infinite cylinder intersection core.
// Used by ray_cylinder_intersect_core and by its checker rci_checker; no dependencies.
package rci_pkg;

  // Width of every coordinate on the ports.
  localparam int COORD_W = 32;

  // Pipeline shape: front end, square root, root selection, products, divider, output.
  localparam int FRONT_STAGES = 6;
  localparam int SQRT_STAGES  = 64;
  localparam int QUOT_BITS    = 33;
  localparam int DIV_STAGES   = QUOT_BITS + 1;
  localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + 3 + DIV_STAGES + 1;

  // Ray data and shared terms that travel alongside the arithmetic.
  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] oz;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dz;
    logic        [63:0]        a;
    logic signed [64:0]        h;
    logic                      miss;
  } carry_t;

endpackage

// ===== design/ray_cylinder_intersect_core.sv =====
// Ray against infinite unit cylinder around the y axis, fully pipelined.
// Depends on rci_pkg for the carried item type and the pipeline constants.

// The core takes one ray per clock and returns its result with done_o high
// for a single cycle; busy_o never rises. The latency is set by the 64-stage
// digit-by-digit square root of the 128-bit discriminant and the 34-stage
// restoring divider that forms the three impact offsets in parallel. Results
// cannot be held off, so the sink must take every item on the cycle it
// appears. On a miss hit_o is low and the impact coordinates are zero.
module ray_cylinder_intersect_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [rci_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [rci_pkg::COORD_W-1:0] origin_y_i,
  input  logic signed [rci_pkg::COORD_W-1:0] origin_z_i,
  input  logic signed [rci_pkg::COORD_W-1:0] dir_x_i,
  input  logic signed [rci_pkg::COORD_W-1:0] dir_y_i,
  input  logic signed [rci_pkg::COORD_W-1:0] dir_z_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic signed [rci_pkg::COORD_W-1:0] impact_x_o,
  output logic signed [rci_pkg::COORD_W-1:0] impact_y_o,
  output logic signed [rci_pkg::COORD_W-1:0] impact_z_o
);

  localparam logic [63:0] ONE  = 64'd1 << (2 * FRAC_BITS);
  localparam int          NSQ  = rci_pkg::SQRT_STAGES;
  localparam int          NDV  = rci_pkg::DIV_STAGES;

  // Picks the origin or direction component of one axis from a carried item.
  function automatic logic signed [31:0] pick_o(rci_pkg::carry_t c, logic [1:0] j);
    logic signed [31:0] r;
    r = (j == 2'd0) ? c.ox : ((j == 2'd1) ? c.oy : c.oz);
    return r;
  endfunction

  function automatic logic signed [31:0] pick_d(rci_pkg::carry_t c, logic [1:0] j);
    logic signed [31:0] r;
    r = (j == 2'd0) ? c.dx : ((j == 2'd1) ? c.dy : c.dz);
    return r;
  endfunction

  // The pipeline never stalls, so an item is taken on every cycle.
  assign busy_o = 1'b0;

  // Stage 1: the six 32 by 32 products.
  logic               s1_v_q;
  logic signed [63:0] s1_oxdx_q, s1_ozdz_q, s1_dx2_q, s1_dz2_q, s1_ox2_q, s1_oz2_q;
  rci_pkg::carry_t    s1_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_oxdx_q <= origin_x_i * dir_x_i;
    s1_ozdz_q <= origin_z_i * dir_z_i;
    s1_dx2_q  <= dir_x_i * dir_x_i;
    s1_dz2_q  <= dir_z_i * dir_z_i;
    s1_ox2_q  <= origin_x_i * origin_x_i;
    s1_oz2_q  <= origin_z_i * origin_z_i;
    s1_c_q.ox   <= origin_x_i;
    s1_c_q.oy   <= origin_y_i;
    s1_c_q.oz   <= origin_z_i;
    s1_c_q.dx   <= dir_x_i;
    s1_c_q.dy   <= dir_y_i;
    s1_c_q.dz   <= dir_z_i;
    s1_c_q.a    <= '0;
    s1_c_q.h    <= '0;
    s1_c_q.miss <= 1'b0;
  end

  // Stage 2: quadratic coefficients a, h and c.
  logic               s2_v_q;
  logic signed [64:0] s2_c_q;
  rci_pkg::carry_t    s2_k_q;
  rci_pkg::carry_t    s2_k_d;
  logic        [63:0] s2_r2_d;

  assign s2_r2_d = $unsigned(s1_ox2_q) + $unsigned(s1_oz2_q);

  always_comb begin
    s2_k_d   = s1_c_q;
    s2_k_d.a = $unsigned(s1_dx2_q) + $unsigned(s1_dz2_q);
    s2_k_d.h = {s1_oxdx_q[63], s1_oxdx_q} + {s1_ozdz_q[63], s1_ozdz_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_k_q   <= s2_k_d;
    s2_c_q   <= $signed({1'b0, s2_r2_d}) - $signed({1'b0, ONE});
  end

  // Stage 3: magnitudes of h and c.
  logic            s3_v_q, s3_cneg_q;
  logic [63:0]     s3_hm_q, s3_cm_q;
  rci_pkg::carry_t s3_k_q;
  logic [64:0]     s3_habs_d, s3_cabs_d;

  assign s3_habs_d = s2_k_q.h[64] ? (~s2_k_q.h + 65'd1) : s2_k_q.h;
  assign s3_cabs_d = s2_c_q[64] ? (~s2_c_q + 65'd1) : s2_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_k_q    <= s2_k_q;
    s3_hm_q   <= s3_habs_d[63:0];
    s3_cm_q   <= s3_cabs_d[63:0];
    s3_cneg_q <= s2_c_q[64];
  end

  // Stage 4: 32-bit partial products of h*h and a*|c|.
  logic            s4_v_q, s4_cneg_q;
  logic [63:0]     s4_hll_q, s4_hlh_q, s4_hhh_q;
  logic [63:0]     s4_all_q, s4_alh_q, s4_ahl_q, s4_ahh_q;
  rci_pkg::carry_t s4_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_k_q    <= s3_k_q;
    s4_cneg_q <= s3_cneg_q;
    s4_hll_q  <= 64'(s3_hm_q[31:0])  * 64'(s3_hm_q[31:0]);
    s4_hlh_q  <= 64'(s3_hm_q[31:0])  * 64'(s3_hm_q[63:32]);
    s4_hhh_q  <= 64'(s3_hm_q[63:32]) * 64'(s3_hm_q[63:32]);
    s4_all_q  <= 64'(s3_k_q.a[31:0])  * 64'(s3_cm_q[31:0]);
    s4_alh_q  <= 64'(s3_k_q.a[31:0])  * 64'(s3_cm_q[63:32]);
    s4_ahl_q  <= 64'(s3_k_q.a[63:32]) * 64'(s3_cm_q[31:0]);
    s4_ahh_q  <= 64'(s3_k_q.a[63:32]) * 64'(s3_cm_q[63:32]);
  end

  // Stage 5: assemble the two 128-bit products.
  logic            s5_v_q, s5_cneg_q;
  logic [127:0]    s5_hsq_q, s5_acm_q;
  rci_pkg::carry_t s5_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_k_q    <= s4_k_q;
    s5_cneg_q <= s4_cneg_q;
    s5_hsq_q  <= {s4_hhh_q, 64'd0} + {31'd0, s4_hlh_q, 33'd0} + {64'd0, s4_hll_q};
    s5_acm_q  <= {s4_ahh_q, 64'd0} + {32'd0, s4_alh_q, 32'd0}
               + {32'd0, s4_ahl_q, 32'd0} + {64'd0, s4_all_q};
  end

  // Stage 6: discriminant; an axis-parallel ray or a negative discriminant misses.
  logic [128:0]    s6_disc_d;
  rci_pkg::carry_t s6_k_d;

  assign s6_disc_d = s5_cneg_q ? ({1'b0, s5_hsq_q} + {1'b0, s5_acm_q})
                               : ({1'b0, s5_hsq_q} - {1'b0, s5_acm_q});

  always_comb begin
    s6_k_d      = s5_k_q;
    s6_k_d.miss = (s5_k_q.a == 64'd0) || s6_disc_d[128];
  end

  // Square root pipeline: index 0 is stage 6, each later index adds one root bit.
  logic            sq_v_q    [0:NSQ];
  logic [66:0]     sq_rem_q  [0:NSQ];
  logic [63:0]     sq_root_q [0:NSQ];
  logic [127:0]    sq_rad_q  [0:NSQ];
  rci_pkg::carry_t sq_k_q    [0:NSQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_k_q[0]      <= s6_k_d;
    sq_rem_q[0]    <= '0;
    sq_root_q[0]   <= '0;
    sq_rad_q[0]    <= s6_disc_d[127:0];
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [66:0] rem_t, trial;
    logic        ge;

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_t = {sq_rem_q[k][64:0], sq_rad_q[k][127:126]};
    assign trial = {1'b0, sq_root_q[k], 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_k_q[k+1]    <= sq_k_q[k];
      sq_rem_q[k+1]  <= ge ? (rem_t - trial) : rem_t;
      sq_root_q[k+1] <= {sq_root_q[k][62:0], ge};
      sq_rad_q[k+1]  <= {sq_rad_q[k][125:0], 2'b00};
    end
  end

  // Root selection: the nearer root if positive, else the farther one.
  logic signed [66:0] ns_nh_d, ns_s_d, ns_n1_d, ns_n2_d;
  logic               ns_p1_d, ns_p2_d;
  logic               ns_v_q;
  logic        [64:0] ns_n_q;
  rci_pkg::carry_t    ns_k_q;
  rci_pkg::carry_t    ns_k_d;

  assign ns_nh_d = -{{2{sq_k_q[NSQ].h[64]}}, sq_k_q[NSQ].h};
  assign ns_s_d  = $signed({3'b000, sq_root_q[NSQ]});
  assign ns_n1_d = ns_nh_d - ns_s_d;
  assign ns_n2_d = ns_nh_d + ns_s_d;
  assign ns_p1_d = !ns_n1_d[66] && (ns_n1_d != 67'sd0);
  assign ns_p2_d = !ns_n2_d[66] && (ns_n2_d != 67'sd0);

  always_comb begin
    ns_k_d      = sq_k_q[NSQ];
    ns_k_d.miss = sq_k_q[NSQ].miss || (!ns_p1_d && !ns_p2_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_v_q <= 1'b0;
    end else begin
      ns_v_q <= sq_v_q[NSQ];
    end
  end

  always_ff @(posedge clk_i) begin
    ns_k_q      <= ns_k_d;
    ns_n_q      <= ns_p1_d ? ns_n1_d[64:0] : ns_n2_d[64:0];
  end

  // Numerator products n*|d| per axis, split in two partial products.
  logic            pp_v_q;
  logic [63:0]     pp_lo_q [0:2];
  logic [64:0]     pp_hi_q [0:2];
  rci_pkg::carry_t pp_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q <= 1'b0;
    end else begin
      pp_v_q <= ns_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_k_q <= ns_k_q;
  end

  // Divider pipeline: index 0 holds the numerators, the last index the quotients.
  logic            dv_v_q   [0:NDV];
  rci_pkg::carry_t dv_k_q   [0:NDV];
  logic [95:0]     dv_rem_q [0:NDV][0:2];
  logic [32:0]     dv_quo_q [0:NDV][0:2];
  logic            dv_sat_q [0:NDV][0:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= pp_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_k_q[0] <= pp_k_q;
  end

  for (genvar j = 0; j < 3; j++) begin : g_axis
    logic signed [31:0] d_v;
    logic        [31:0] md;
    logic        [96:0] num_full;

    assign d_v      = pick_d(ns_k_q, 2'(j));
    assign md       = d_v[31] ? (~d_v + 32'd1) : d_v;
    assign num_full = {pp_hi_q[j], 32'd0} + {33'd0, pp_lo_q[j]};

    always_ff @(posedge clk_i) begin
      pp_lo_q[j]     <= 64'(ns_n_q[31:0]) * 64'(md);
      pp_hi_q[j]     <= 65'(ns_n_q[64:32]) * 65'(md);
      dv_rem_q[0][j] <= num_full[95:0];
      dv_quo_q[0][j] <= '0;
      dv_sat_q[0][j] <= 1'b0;
    end
  end

  for (genvar s = 1; s <= NDV; s++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[s] <= 1'b0;
      end else begin
        dv_v_q[s] <= dv_v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_k_q[s] <= dv_k_q[s-1];
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      if (s == 1) begin : g_range
        // A quotient of 2^33 or more saturates the coordinate.
        always_ff @(posedge clk_i) begin
          dv_rem_q[s][j] <= dv_rem_q[s-1][j];
          dv_quo_q[s][j] <= '0;
          dv_sat_q[s][j] <= {1'b0, dv_rem_q[s-1][j]} >= {dv_k_q[s-1].a, 33'd0};
        end
      end else begin : g_step
        localparam int SH = NDV - s;
        logic [96:0] dsh;
        logic        ge;
        logic [32:0] quo;

        // Restoring step for one quotient bit.
        assign dsh = {33'd0, dv_k_q[s-1].a} << SH;
        assign ge  = {1'b0, dv_rem_q[s-1][j]} >= dsh;

        always_comb begin
          quo     = dv_quo_q[s-1][j];
          quo[SH] = ge;
        end

        always_ff @(posedge clk_i) begin
          dv_rem_q[s][j] <= ge ? (dv_rem_q[s-1][j] - dsh[95:0]) : dv_rem_q[s-1][j];
          dv_quo_q[s][j] <= quo;
          dv_sat_q[s][j] <= dv_sat_q[s-1][j];
        end
      end
    end
  end

  // Output stage: origin plus signed offset, saturated; zero on a miss.
  logic        [31:0] res_d [0:2];
  logic               done_q, hit_q;
  logic signed [31:0] imp_q [0:2];

  for (genvar j = 0; j < 3; j++) begin : g_out
    logic signed [31:0] o_v, d_v;
    logic signed [34:0] off, sum;

    assign o_v = pick_o(dv_k_q[NDV], 2'(j));
    assign d_v = pick_d(dv_k_q[NDV], 2'(j));
    assign off = d_v[31] ? -$signed({2'b00, dv_quo_q[NDV][j]})
                         : $signed({2'b00, dv_quo_q[NDV][j]});
    assign sum = {{3{o_v[31]}}, o_v} + off;

    always_comb begin
      if (dv_k_q[NDV].miss) begin
        res_d[j] = '0;
      end else if (dv_sat_q[NDV][j]) begin
        res_d[j] = d_v[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (sum > 35'sh7FFF_FFFF) begin
        res_d[j] = 32'h7FFF_FFFF;
      end else if (sum < -35'sh8000_0000) begin
        res_d[j] = 32'h8000_0000;
      end else begin
        res_d[j] = sum[31:0];
      end
    end

    always_ff @(posedge clk_i) begin
      imp_q[j] <= $signed(res_d[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      done_q <= dv_v_q[NDV];
      hit_q  <= dv_v_q[NDV] && !dv_k_q[NDV].miss;
    end
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign impact_x_o = imp_q[0];
  assign impact_y_o = imp_q[1];
  assign impact_z_o = imp_q[2];

endmodule

// ===== design/rci_checker.sv =====
// Port-level checks for ray_cylinder_intersect_core, bound to every instance.
// Depends on rci_pkg for the latency and coordinate width.
module rci_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic signed [rci_pkg::COORD_W-1:0] dir_x_i,
  input logic signed [rci_pkg::COORD_W-1:0] dir_z_i,
  input logic                               done_o,
  input logic                               hit_o,
  input logic signed [rci_pkg::COORD_W-1:0] impact_x_o,
  input logic signed [rci_pkg::COORD_W-1:0] impact_y_o,
  input logic signed [rci_pkg::COORD_W-1:0] impact_z_o
);

  localparam int LAT = rci_pkg::LATENCY;

  // Counts cycles since reset so that look-backs only span reset-free history.
  logic [7:0] warm_q;
  logic       warm;

  assign warm = (warm_q == 8'(LAT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (!warm) begin
      warm_q <= warm_q + 8'd1;
    end
  end

  // The core accepts an item on every cycle.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o asserted");

  // Each accepted item yields exactly one result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (done_o == $past(start_i && !busy_o, LAT)))
    else $error("result strobe does not match accepted item");

  // A miss reports zero coordinates.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (impact_x_o == '0 && impact_y_o == '0 && impact_z_o == '0))
    else $error("miss with non-zero impact");

  // No hit is shown outside a result cycle.
  a_hit_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !hit_o)
    else $error("hit without result strobe");

  // A ray parallel to the axis never hits.
  a_parallel_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o && $past(start_i && dir_x_i == '0 && dir_z_i == '0, LAT)) |-> !hit_o)
    else $error("axis-parallel ray reported a hit");

endmodule

bind ray_cylinder_intersect_core rci_checker u_rci_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .dir_x_i    (dir_x_i),
  .dir_z_i    (dir_z_i),
  .done_o     (done_o),
  .hit_o      (hit_o),
  .impact_x_o (impact_x_o),
  .impact_y_o (impact_y_o),
  .impact_z_o (impact_z_o)
);
